// ===== sv/lfas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfas_pkg
// Shared types, sizes and the direction table for line_fit_angle_sweep.
// ----------------------------------------------------------------------------
package lfas_pkg;

    localparam int MaxPoints = 1024;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = AddrW + 1;
    localparam int Segments  = 64;
    localparam int DirW      = $clog2(Segments);
    localparam int CoordW    = 16;
    localparam int SumW      = CoordW + AddrW;      // signed sum of all points
    localparam int DeltaW    = CoordW + 1;          // centered coordinate
    localparam int ProdW     = DeltaW + CoordW;
    localparam int MagW      = 18;                  // |v| >> 15, |v| < 2^32
    localparam int AccW      = MagW + AddrW;
    localparam int DivSteps  = SumW;
    localparam int StepW     = $clog2(DivSteps);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_DIV,
        ST_SIGN,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [CoordW-1:0] c;
        logic signed [CoordW-1:0] s;
    } t_dir;

    // sin(j*pi/32) in Q15, rounded, j = 0..16
    function automatic logic signed [CoordW:0] quarter_sin(input logic [4:0] j);
        logic signed [CoordW:0] v;
        case (j)
            5'd0:    v = 17'sd0;
            5'd1:    v = 17'sd3212;
            5'd2:    v = 17'sd6393;
            5'd3:    v = 17'sd9512;
            5'd4:    v = 17'sd12540;
            5'd5:    v = 17'sd15447;
            5'd6:    v = 17'sd18205;
            5'd7:    v = 17'sd20788;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd25330;
            5'd10:   v = 17'sd27246;
            5'd11:   v = 17'sd28899;
            5'd12:   v = 17'sd30274;
            5'd13:   v = 17'sd31357;
            5'd14:   v = 17'sd32138;
            5'd15:   v = 17'sd32610;
            5'd16:   v = 17'sd32768;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [CoordW-1:0] sat16(input logic signed [CoordW:0] v);
        logic signed [CoordW-1:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[CoordW-1:0];
        end
        return r;
    endfunction

    // cos/sin of 2*pi*k/64: quadrant from k[5:4], first-quadrant step from k[3:0]
    function automatic t_dir dir_lookup(input logic [DirW-1:0] k);
        logic [4:0]             j;
        logic signed [CoordW:0] sj;
        logic signed [CoordW:0] cj;
        logic signed [CoordW:0] c;
        logic signed [CoordW:0] s;
        t_dir                   d;
        j  = {1'b0, k[3:0]};
        sj = quarter_sin(j);
        cj = quarter_sin(5'd16 - j);
        case (k[5:4])
            2'd0: begin
                c = cj;
                s = sj;
            end
            2'd1: begin
                c = -sj;
                s = cj;
            end
            2'd2: begin
                c = -cj;
                s = -sj;
            end
            default: begin
                c = sj;
                s = -cj;
            end
        endcase
        d.c = sat16(c);
        d.s = sat16(s);
        return d;
    endfunction

endpackage

// ===== sv/line_fit_angle_sweep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fit_angle_sweep
// Stores a set of Q12.4 points, finds the mean center and picks the direction
// out of 64 with the smallest sum of perpendicular distances.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 word
//  in       in   i_in_valid / o_in_stall   point_x, point_y, last_point
//  out      out  o_out_valid / i_out_stall center, best_angle, cos/sin, overflow
//
// Points load at one per cycle. After the last point, a 26-step restoring
// divider finds the center, then the sweep covers 64 directions, reading
// one stored point per cycle through the single read port of the point
// store; pipeline drain and handoff follow. Reset is synchronous, active
// low, and needs no clearing pass. A held result does not block loading of
// the next set; only its handoff waits for the output word to be taken.
// ----------------------------------------------------------------------------
module line_fit_angle_sweep
    import lfas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [CoordW-1:0] i_point_x,
    input  logic signed [CoordW-1:0] i_point_y,
    input  logic                     i_last_point,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [CoordW-1:0] o_center_x,
    output logic signed [CoordW-1:0] o_center_y,
    output logic [DirW-1:0]          o_best_angle,
    output logic signed [CoordW-1:0] o_dir_cos,
    output logic signed [CoordW-1:0] o_dir_sin,
    output logic                     o_overflow
);

    t_state r_state;
    t_state n_state;

    logic [2*CoordW-1:0] r_mem [MaxPoints];
    logic [2*CoordW-1:0] r_rd_data;

    logic [CntW-1:0]        r_count;
    logic signed [SumW-1:0] r_sum_x;
    logic signed [SumW-1:0] r_sum_y;
    logic                   r_dropped;

    logic [StepW-1:0]   r_dstep;
    logic [SumW-1:0]    r_qx;
    logic [SumW-1:0]    r_qy;
    logic [AddrW+1:0]   r_rx;
    logic [AddrW+1:0]   r_ry;
    logic [AddrW+1:0]   w_tx;
    logic [AddrW+1:0]   w_ty;
    logic [SumW-1:0]    w_cx_full;
    logic [SumW-1:0]    w_cy_full;
    logic signed [CoordW-1:0] r_cx;
    logic signed [CoordW-1:0] r_cy;

    logic [AddrW-1:0] r_i;
    logic [DirW-1:0]  r_k;
    logic [AddrW-1:0] w_last_idx;
    logic             w_issue;
    logic             w_end_dir;

    logic             w_in_acc;
    logic             w_store;
    logic             w_out_load;
    logic             w_pipe_busy;

    // sweep pipeline: s0 read, s1 deltas, s2 products, s3 magnitude, s4 sum
    logic                     r_s0_valid, r_s0_first, r_s0_last;
    logic [DirW-1:0]          r_s0_k;
    logic                     r_s1_valid, r_s1_first, r_s1_last;
    logic [DirW-1:0]          r_s1_k;
    logic signed [DeltaW-1:0] r_dx, r_dy;
    logic signed [CoordW-1:0] r_c, r_s;
    logic                     r_s2_valid, r_s2_first, r_s2_last;
    logic [DirW-1:0]          r_s2_k;
    logic signed [ProdW-1:0]  r_p1, r_p2;
    logic                     r_s3_valid, r_s3_first, r_s3_last;
    logic [DirW-1:0]          r_s3_k;
    logic [MagW-1:0]          r_mag;
    logic                     r_s4_valid, r_s4_last;
    logic [DirW-1:0]          r_s4_k;
    logic [AccW-1:0]          r_acc;

    logic [AccW-1:0]  r_best_sum;
    logic [DirW-1:0]  r_best_idx;

    logic signed [DeltaW-1:0] w_px, w_py;
    logic signed [ProdW:0]    w_v;
    logic [ProdW:0]           w_v_abs;
    t_dir                     w_dir;
    t_dir                     w_best_dir;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign w_in_acc    = i_in_valid && (r_state == ST_LOAD);
    assign w_store     = w_in_acc && (r_count < CntW'(MaxPoints));
    assign w_out_load  = (r_state == ST_DONE) && (!o_out_valid || !i_out_stall);
    assign w_last_idx  = AddrW'(r_count - CntW'(1));
    assign w_issue     = (r_state == ST_SWEEP);
    assign w_end_dir   = (r_i == w_last_idx);
    assign w_pipe_busy = r_s0_valid || r_s1_valid || r_s2_valid || r_s3_valid
                         || r_s4_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last_point) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_dstep == StepW'(DivSteps - 1)) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (w_end_dir && (r_k == DirW'(Segments - 1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // point store: writes only while loading; the read port runs every cycle,
    // but its data is used only while sweeping, when no write takes place
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AddrW-1:0]] <= {i_point_y, i_point_x};
        end
        r_rd_data <= r_mem[r_i];
    end

    // set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_dropped <= 1'b0;
        end else if (w_out_load) begin
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_dropped <= 1'b0;
        end else if (w_in_acc) begin
            if (w_store) begin
                r_count <= r_count + CntW'(1);
                r_sum_x <= r_sum_x + SumW'(i_point_x);
                r_sum_y <= r_sum_y + SumW'(i_point_y);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // restoring divider on magnitudes, one quotient bit per cycle per axis
    assign w_tx = {r_rx[AddrW:0], r_qx[SumW-1]} - {1'b0, r_count};
    assign w_ty = {r_ry[AddrW:0], r_qy[SumW-1]} - {1'b0, r_count};
    assign w_cx_full = r_sum_x[SumW-1] ? (SumW'(0) - r_qx) : r_qx;
    assign w_cy_full = r_sum_y[SumW-1] ? (SumW'(0) - r_qy) : r_qy;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SETUP: begin
                r_dstep <= '0;
                r_rx    <= '0;
                r_ry    <= '0;
                r_qx    <= r_sum_x[SumW-1] ? (SumW'(0) - r_sum_x) : r_sum_x;
                r_qy    <= r_sum_y[SumW-1] ? (SumW'(0) - r_sum_y) : r_sum_y;
            end
            ST_DIV: begin
                r_dstep <= r_dstep + StepW'(1);
                if (!w_tx[AddrW+1]) begin
                    r_rx <= w_tx;
                    r_qx <= {r_qx[SumW-2:0], 1'b1};
                end else begin
                    r_rx <= {r_rx[AddrW:0], r_qx[SumW-1]};
                    r_qx <= {r_qx[SumW-2:0], 1'b0};
                end
                if (!w_ty[AddrW+1]) begin
                    r_ry <= w_ty;
                    r_qy <= {r_qy[SumW-2:0], 1'b1};
                end else begin
                    r_ry <= {r_ry[AddrW:0], r_qy[SumW-1]};
                    r_qy <= {r_qy[SumW-2:0], 1'b0};
                end
            end
            ST_SIGN: begin
                r_cx <= w_cx_full[CoordW-1:0];
                r_cy <= w_cy_full[CoordW-1:0];
            end
            default: begin
            end
        endcase
    end

    // read address sequencer: points inner, directions outer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_k <= '0;
        end else if (r_state == ST_SIGN) begin
            r_i <= '0;
            r_k <= '0;
        end else if (w_issue) begin
            if (w_end_dir) begin
                r_i <= '0;
                r_k <= r_k + DirW'(1);
            end else begin
                r_i <= r_i + AddrW'(1);
            end
        end
    end

    assign w_dir = dir_lookup(r_s0_k);
    assign w_px  = DeltaW'(signed'(r_rd_data[CoordW-1:0]));
    assign w_py  = DeltaW'(signed'(r_rd_data[2*CoordW-1:CoordW]));
    assign w_v   = (ProdW+1)'(r_p1) - (ProdW+1)'(r_p2);
    assign w_v_abs = w_v[ProdW] ? ((ProdW+1)'(0) - w_v) : w_v;

    // pipeline valids and tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_issue;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_k     <= r_k;
        r_s0_first <= (r_i == '0);
        r_s0_last  <= w_end_dir;

        r_s1_k     <= r_s0_k;
        r_s1_first <= r_s0_first;
        r_s1_last  <= r_s0_last;
        r_dx       <= w_px - DeltaW'(r_cx);
        r_dy       <= w_py - DeltaW'(r_cy);
        r_c        <= w_dir.c;
        r_s        <= w_dir.s;

        r_s2_k     <= r_s1_k;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_p1       <= r_dy * r_c;
        r_p2       <= r_dx * r_s;

        r_s3_k     <= r_s2_k;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;
        r_mag      <= w_v_abs[MagW+14:15];

        if (r_s3_valid) begin
            r_s4_k    <= r_s3_k;
            r_s4_last <= r_s3_last;
            r_acc     <= r_s3_first ? AccW'(r_mag) : (r_acc + AccW'(r_mag));
        end
    end

    // keep the earlier direction on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_sum <= '0;
            r_best_idx <= '0;
        end else if (r_s4_valid && r_s4_last) begin
            if ((r_s4_k == '0) || (r_acc < r_best_sum)) begin
                r_best_sum <= r_acc;
                r_best_idx <= r_s4_k;
            end
        end
    end

    assign w_best_dir = dir_lookup(r_best_idx);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_center_x   <= r_cx;
            o_center_y   <= r_cy;
            o_best_angle <= r_best_idx;
            o_dir_cos    <= w_best_dir.c;
            o_dir_sin    <= w_best_dir.s;
            o_overflow   <= r_dropped;
        end
    end

endmodule
